[sv/tpa_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle primitive assembler package
// Shared codes, field widths, item structures and fixed-point helpers.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned CfgIdxW = 2;

    // Item function codes.
    localparam logic [1:0] FUNC_VERTEX = 2'd0;
    localparam logic [1:0] FUNC_BEGIN  = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;

    // Primitive modes.
    localparam logic [1:0] MODE_TRIANGLES = 2'd0;
    localparam logic [1:0] MODE_FAN       = 2'd1;
    localparam logic [1:0] MODE_STRIP     = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_BACK_FACE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TEX_GEN    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INV_HEIGHT = 2'd2;

    localparam logic [CoordW-1:0] INV_HEIGHT_RESET = 24'd65536;

    localparam logic signed [CoordW-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] S24_MIN = 24'sh800000;

    typedef struct packed {
        logic                     back_face;
        logic                     tex_gen_enable;
        logic [CoordW-1:0]        inv_text_height;
    } t_cfg;

    // Item after the pen offset has been applied.
    typedef struct packed {
        logic [1:0]               func;
        logic [1:0]               prim_mode;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
    } t_vtx_item;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] s;
        logic signed [CoordW-1:0] t;
    } t_slot;

    typedef struct packed {
        logic signed [CoordW-1:0] a_x;
        logic signed [CoordW-1:0] a_y;
        logic signed [CoordW-1:0] b_x;
        logic signed [CoordW-1:0] b_y;
        logic signed [CoordW-1:0] c_x;
        logic signed [CoordW-1:0] c_y;
        logic signed [CoordW-1:0] a_s;
        logic signed [CoordW-1:0] a_t;
        logic signed [CoordW-1:0] b_s;
        logic signed [CoordW-1:0] b_t;
        logic signed [CoordW-1:0] c_s;
        logic signed [CoordW-1:0] c_t;
    } t_tri;

    // Saturating add of two 24-bit signed values.
    function automatic logic signed [CoordW-1:0] sat_add24(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b
    );
        logic signed [CoordW:0] sum;
        begin
            sum = {a[CoordW-1], a} + {b[CoordW-1], b};
            if (sum[CoordW] != sum[CoordW-1]) begin
                sat_add24 = sum[CoordW] ? S24_MIN : S24_MAX;
            end else begin
                sat_add24 = sum[CoordW-1:0];
            end
        end
    endfunction

    // Position times the Q8.16 reciprocal, rounded to nearest (ties up),
    // saturated to 24 bits.
    function automatic logic signed [CoordW-1:0] scale_tex(
        input logic signed [CoordW-1:0] p,
        input logic [CoordW-1:0]        inv
    );
        logic signed [2*CoordW:0] prod;
        logic signed [2*CoordW:0] rnd;
        begin
            prod = p * $signed({1'b0, inv});
            rnd  = prod + 49'sd32768;
            // The quotient is rnd[48:16]; it fits when its top bits agree.
            if (rnd[2*CoordW:CoordW+15] != {10{rnd[CoordW+15]}}) begin
                scale_tex = rnd[2*CoordW] ? S24_MIN : S24_MAX;
            end else begin
                scale_tex = rnd[CoordW+15:16];
            end
        end
    endfunction

    // Negation with the most negative value mapped to the most positive.
    function automatic logic signed [CoordW-1:0] sat_neg24(
        input logic signed [CoordW-1:0] v
    );
        begin
            sat_neg24 = (v == S24_MIN) ? S24_MAX : -v;
        end
    endfunction

endpackage

[sv/tpa_vertex_stage.sv]
// ----------------------------------------------------------------------------
// Vertex input stage
// Takes one item per cycle while the assembler advances, applies the pen
// offset and holds the item until the assembler stage consumes it.
// ----------------------------------------------------------------------------
module tpa_vertex_stage
    import tpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_func,
    input  logic [1:0]               i_prim_mode,
    input  logic signed [CoordW-1:0] i_vert_x,
    input  logic signed [CoordW-1:0] i_vert_y,
    input  logic signed [CoordW-1:0] i_pen_x,
    input  logic signed [CoordW-1:0] i_pen_y,
    input  logic                     i_advance,
    output logic                     o_item_valid,
    output t_vtx_item                o_item
);

    logic      r_valid;
    logic      n_valid;
    t_vtx_item r_item;
    t_vtx_item n_item;
    logic      load;

    assign load = !r_valid || i_advance;

    always_comb begin
        n_valid          = load ? i_valid : r_valid;
        n_item.func      = i_func;
        n_item.prim_mode = i_prim_mode;
        n_item.x         = sat_add24(i_vert_x, i_pen_x);
        n_item.y         = sat_add24(i_vert_y, i_pen_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_stall      = !load;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[sv/tpa_assembler.sv]
// ----------------------------------------------------------------------------
// Triangle assembler stage
// Generates texture coordinates, fills the three vertex slots and loads a
// finished triangle into the result register.
// ----------------------------------------------------------------------------
module tpa_assembler
    import tpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_item_valid,
    input  t_vtx_item i_item,
    output logic      o_advance,
    output logic      o_valid,
    input  logic      i_stall,
    output t_tri      o_tri
);

    logic       r_out_valid;
    logic       n_out_valid;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic [1:0] r_mode;
    logic [1:0] n_mode;
    t_slot      r_slot [0:2];
    t_tri       r_tri;
    t_tri       n_tri;

    logic       proc;
    logic       is_vertex;
    logic [1:0] wr_idx;
    logic       emit;
    t_slot      new_vtx;
    t_slot      va;
    t_slot      vb;
    t_slot      vc;

    // Nothing moves while a finished triangle waits on a stalled receiver.
    assign o_advance = !(r_out_valid && i_stall);
    assign proc      = i_item_valid && o_advance;
    assign is_vertex = (i_item.func == FUNC_VERTEX);
    assign wr_idx    = (r_fill == 2'd3) ? 2'd0 : r_fill;
    assign emit      = proc && is_vertex && (wr_idx == 2'd2);

    always_comb begin
        new_vtx.x = i_item.x;
        new_vtx.y = i_item.y;
        new_vtx.s = '0;
        new_vtx.t = '0;
        if (i_cfg.tex_gen_enable) begin
            new_vtx.s = scale_tex(i_item.x, i_cfg.inv_text_height);
            new_vtx.t = scale_tex(i_item.y, i_cfg.inv_text_height);
            if (i_cfg.back_face) begin
                new_vtx.s = sat_neg24(new_vtx.s);
            end
        end
    end

    // Next fill count and mode.
    always_comb begin
        n_fill = r_fill;
        n_mode = r_mode;
        if (proc) begin
            unique case (i_item.func)
                FUNC_BEGIN: begin
                    n_mode = i_item.prim_mode;
                    n_fill = 2'd0;
                end
                FUNC_END: begin
                    n_fill = 2'd0;
                end
                FUNC_VERTEX: begin
                    if (wr_idx == 2'd2) begin
                        n_fill = (r_mode == MODE_FAN || r_mode == MODE_STRIP) ? 2'd2 : 2'd0;
                    end else begin
                        n_fill = wr_idx + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_cfg.back_face) begin
            va = new_vtx;
            vb = r_slot[1];
            vc = r_slot[0];
        end else begin
            va = r_slot[0];
            vb = r_slot[1];
            vc = new_vtx;
        end
        n_tri.a_x = va.x;
        n_tri.a_y = va.y;
        n_tri.b_x = vb.x;
        n_tri.b_y = vb.y;
        n_tri.c_x = vc.x;
        n_tri.c_y = vc.y;
        n_tri.a_s = va.s;
        n_tri.a_t = va.t;
        n_tri.b_s = vb.s;
        n_tri.b_t = vb.t;
        n_tri.c_s = vc.s;
        n_tri.c_t = vc.t;
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= 2'd0;
            r_mode      <= MODE_TRIANGLES;
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_mode      <= n_mode;
        end
    end

    // A fan keeps its hub in slot 0; a strip slides its window down by one.
    always_ff @(posedge i_clk) begin
        if (proc && is_vertex) begin
            r_slot[wr_idx] <= new_vtx;
            if (wr_idx == 2'd2) begin
                if (r_mode == MODE_FAN) begin
                    r_slot[1] <= new_vtx;
                end else if (r_mode == MODE_STRIP) begin
                    r_slot[0] <= r_slot[1];
                    r_slot[1] <= new_vtx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tri <= n_tri;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tri   = r_tri;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("fill count left its range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !proc)
        else $error("item consumed while a triangle waits on the receiver");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("completed triangle not presented");

    a_window_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_mode == MODE_FAN || r_mode == MODE_STRIP)) |=> (r_fill == 2'd2))
        else $error("fan or strip window not kept after a triangle");

endmodule

[sv/triangle_primitive_assembler_top.sv]
// ----------------------------------------------------------------------------
// Triangle primitive assembler
// Builds triangles (independent, fan or strip) from a vertex item stream.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with func, prim_mode, vertex and pen fields.
// A begin item sets the primitive mode, an end item clears the fill count, and
// a vertex item is offset by the pen, given texture coordinates and stored in
// one of three slots. Every completed triangle appears as one item on the
// output channel o_valid / i_stall, reversed in order on the back face.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// ready is always high. Write only while no item is in flight.
// Path: a triangle passes through the pen-offset input register, then through
// the texture multiplier and slot logic into the result register.
// Throughput: one item per cycle while no finished triangle waits on i_stall;
// the result register holds a triangle while i_stall is high, and the input
// stage then fills and raises o_stall.
// Reset clears the fill count, selects independent triangles, and loads the
// registers with back face off, texture generation on and a reciprocal of 1.0.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_top
    import tpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_func,
    input  logic [1:0]               i_prim_mode,
    input  logic signed [CoordW-1:0] i_vert_x,
    input  logic signed [CoordW-1:0] i_vert_y,
    input  logic signed [CoordW-1:0] i_pen_x,
    input  logic signed [CoordW-1:0] i_pen_y,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CoordW-1:0] o_a_x,
    output logic signed [CoordW-1:0] o_a_y,
    output logic signed [CoordW-1:0] o_b_x,
    output logic signed [CoordW-1:0] o_b_y,
    output logic signed [CoordW-1:0] o_c_x,
    output logic signed [CoordW-1:0] o_c_y,
    output logic signed [CoordW-1:0] o_a_s,
    output logic signed [CoordW-1:0] o_a_t,
    output logic signed [CoordW-1:0] o_b_s,
    output logic signed [CoordW-1:0] o_b_t,
    output logic signed [CoordW-1:0] o_c_s,
    output logic signed [CoordW-1:0] o_c_t,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CoordW-1:0]        i_cfg_data
);

    t_cfg      r_cfg;
    t_cfg      n_cfg;
    logic      advance;
    logic      item_valid;
    t_vtx_item item;
    t_tri      tri_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BACK_FACE:  n_cfg.back_face       = i_cfg_data[0];
                CFG_TEX_GEN:    n_cfg.tex_gen_enable  = i_cfg_data[0];
                CFG_INV_HEIGHT: n_cfg.inv_text_height = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.back_face       <= 1'b0;
            r_cfg.tex_gen_enable  <= 1'b1;
            r_cfg.inv_text_height <= INV_HEIGHT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;

    tpa_vertex_stage u_vertex_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_prim_mode  (i_prim_mode),
        .i_vert_x     (i_vert_x),
        .i_vert_y     (i_vert_y),
        .i_pen_x      (i_pen_x),
        .i_pen_y      (i_pen_y),
        .i_advance    (advance),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    tpa_assembler u_assembler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tri        (tri_out)
    );

    assign o_a_x = tri_out.a_x;
    assign o_a_y = tri_out.a_y;
    assign o_b_x = tri_out.b_x;
    assign o_b_y = tri_out.b_y;
    assign o_c_x = tri_out.c_x;
    assign o_c_y = tri_out.c_y;
    assign o_a_s = tri_out.a_s;
    assign o_a_t = tri_out.a_t;
    assign o_b_s = tri_out.b_s;
    assign o_b_t = tri_out.b_t;
    assign o_c_s = tri_out.c_s;
    assign o_c_t = tri_out.c_t;

endmodule

[dv/tpa_triangle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle assembler checker
// Watches the input, result and configuration channels of the triangle
// primitive assembler, predicts every triangle from the accepted items and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tpa_triangle_checker
    import tpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [1:0]               i_func,
    input  logic [1:0]               i_prim_mode,
    input  logic signed [CoordW-1:0] i_vert_x,
    input  logic signed [CoordW-1:0] i_vert_y,
    input  logic signed [CoordW-1:0] i_pen_x,
    input  logic signed [CoordW-1:0] i_pen_y,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [CoordW-1:0] i_a_x,
    input  logic signed [CoordW-1:0] i_a_y,
    input  logic signed [CoordW-1:0] i_b_x,
    input  logic signed [CoordW-1:0] i_b_y,
    input  logic signed [CoordW-1:0] i_c_x,
    input  logic signed [CoordW-1:0] i_c_y,
    input  logic signed [CoordW-1:0] i_a_s,
    input  logic signed [CoordW-1:0] i_a_t,
    input  logic signed [CoordW-1:0] i_b_s,
    input  logic signed [CoordW-1:0] i_b_t,
    input  logic signed [CoordW-1:0] i_c_s,
    input  logic signed [CoordW-1:0] i_c_t,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CoordW-1:0]        i_cfg_data,
    output int                       o_mismatches,
    output int                       o_pending
);

    localparam int unsigned NumFields = 12;
    localparam int unsigned TriW = NumFields * CoordW;
    localparam int unsigned ReportLimit = 10;

    string field_name [NumFields] = '{"a_x", "a_y", "b_x", "b_y", "c_x", "c_y",
                                      "a_s", "a_t", "b_s", "b_t", "c_s", "c_t"};

    // Predicted state of the assembler.
    logic signed [CoordW-1:0] slot_px [3];
    logic signed [CoordW-1:0] slot_py [3];
    logic signed [CoordW-1:0] slot_ts [3];
    logic signed [CoordW-1:0] slot_tt [3];
    int unsigned              slots_filled;
    logic [1:0]               cur_mode;
    logic                     cfg_back_face;
    logic                     cfg_tex_gen;
    logic [CoordW-1:0]        cfg_inv_height;

    t_tri expected_tris [$];
    t_tri want;
    t_tri got;
    logic [TriW-1:0] want_bits;
    logic [TriW-1:0] got_bits;
    int mismatches;

    function automatic logic signed [CoordW-1:0] clamp_s24(input longint v);
        if (v > longint'(S24_MAX)) begin
            return S24_MAX;
        end
        if (v < longint'(S24_MIN)) begin
            return S24_MIN;
        end
        return CoordW'(v);
    endfunction

    // Position times the Q8.16 reciprocal, rounded half up.
    function automatic logic signed [CoordW-1:0] scale_by_inv_height(
        input logic signed [CoordW-1:0] p
    );
        longint prod;
        prod = longint'(p) * longint'(cfg_inv_height) + 64'sd32768;
        return clamp_s24(prod >>> 16);
    endfunction

    function automatic void copy_slot(input int unsigned dst, input int unsigned src);
        slot_px[dst] = slot_px[src];
        slot_py[dst] = slot_py[src];
        slot_ts[dst] = slot_ts[src];
        slot_tt[dst] = slot_tt[src];
    endfunction

    task automatic assemble_item(
        input logic [1:0]               func,
        input logic [1:0]               mode,
        input logic signed [CoordW-1:0] vx,
        input logic signed [CoordW-1:0] vy,
        input logic signed [CoordW-1:0] px,
        input logic signed [CoordW-1:0] py
    );
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] s;
        logic signed [CoordW-1:0] t;
        logic [TriW-1:0]          tri_bits;
        int unsigned              sl;
        case (func)
            FUNC_BEGIN: begin
                cur_mode = mode;
                slots_filled = 0;
            end
            FUNC_END: begin
                slots_filled = 0;
            end
            FUNC_VERTEX: begin
                x = clamp_s24(longint'(vx) + longint'(px));
                y = clamp_s24(longint'(vy) + longint'(py));
                if (cfg_tex_gen) begin
                    s = scale_by_inv_height(x);
                    t = scale_by_inv_height(y);
                    if (cfg_back_face) begin
                        s = clamp_s24(-longint'(s));
                    end
                end else begin
                    s = '0;
                    t = '0;
                end
                slot_px[slots_filled] = x;
                slot_py[slots_filled] = y;
                slot_ts[slots_filled] = s;
                slot_tt[slots_filled] = t;
                slots_filled++;
                if (slots_filled == 3) begin
                    for (int k = 0; k < 3; k++) begin
                        sl = cfg_back_face ? 2 - k : k;
                        tri_bits[CoordW*(11-2*k) +: CoordW] = slot_px[sl];
                        tri_bits[CoordW*(10-2*k) +: CoordW] = slot_py[sl];
                        tri_bits[CoordW*(5-2*k) +: CoordW]  = slot_ts[sl];
                        tri_bits[CoordW*(4-2*k) +: CoordW]  = slot_tt[sl];
                    end
                    expected_tris.push_back(t_tri'(tri_bits));
                    // A fan keeps its hub, a strip slides its window by one vertex.
                    if (cur_mode == MODE_FAN) begin
                        copy_slot(1, 2);
                        slots_filled = 2;
                    end else if (cur_mode == MODE_STRIP) begin
                        copy_slot(0, 1);
                        copy_slot(1, 2);
                        slots_filled = 2;
                    end else begin
                        slots_filled = 0;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                slot_px[k] = '0;
                slot_py[k] = '0;
                slot_ts[k] = '0;
                slot_tt[k] = '0;
            end
            slots_filled = 0;
            cur_mode = MODE_TRIANGLES;
            cfg_back_face = 1'b0;
            cfg_tex_gen = 1'b1;
            cfg_inv_height = INV_HEIGHT_RESET;
            expected_tris.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BACK_FACE:  cfg_back_face = i_cfg_data[0];
                    CFG_TEX_GEN:    cfg_tex_gen = i_cfg_data[0];
                    CFG_INV_HEIGHT: cfg_inv_height = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                assemble_item(i_func, i_prim_mode, i_vert_x, i_vert_y, i_pen_x, i_pen_y);
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y,
                       i_a_s, i_a_t, i_b_s, i_b_t, i_c_s, i_c_t};
                if (expected_tris.size() == 0) begin
                    if (mismatches < ReportLimit) begin
                        $display("[%0t] triangle with none expected: %h", $time, got);
                    end
                    mismatches++;
                end else begin
                    want = expected_tris.pop_front();
                    want_bits = want;
                    got_bits = got;
                    for (int f = 0; f < NumFields; f++) begin
                        if (want_bits[CoordW*(11-f) +: CoordW] !=
                            got_bits[CoordW*(11-f) +: CoordW]) begin
                            if (mismatches < ReportLimit) begin
                                $display("[%0t] field %s: expected %0d, got %0d", $time,
                                         field_name[f],
                                         $signed(want_bits[CoordW*(11-f) +: CoordW]),
                                         $signed(got_bits[CoordW*(11-f) +: CoordW]));
                            end
                            mismatches++;
                        end
                    end
                end
            end
        end
        o_mismatches = mismatches;
        o_pending = expected_tris.size();
    end

endmodule

[dv/triangle_primitive_assembler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle primitive assembler testbench
// Drives begin, end and vertex items in every primitive mode through several
// register settings, with random gaps and stalls on both channels, and lets
// the checker predict and compare every triangle.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_top_tb;
    import tpa_pkg::*;

    localparam logic [1:0]         FUNC_UNUSED = 2'd3;
    localparam logic [1:0]         MODE_UNUSED = 2'd3;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED  = 2'd3;
    localparam int unsigned        WatchdogLimit = 1000;
    localparam int unsigned        LongHold = 100;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [1:0]               i_func;
    logic [1:0]               i_prim_mode;
    logic signed [CoordW-1:0] i_vert_x;
    logic signed [CoordW-1:0] i_vert_y;
    logic signed [CoordW-1:0] i_pen_x;
    logic signed [CoordW-1:0] i_pen_y;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [CoordW-1:0] o_a_x;
    logic signed [CoordW-1:0] o_a_y;
    logic signed [CoordW-1:0] o_b_x;
    logic signed [CoordW-1:0] o_b_y;
    logic signed [CoordW-1:0] o_c_x;
    logic signed [CoordW-1:0] o_c_y;
    logic signed [CoordW-1:0] o_a_s;
    logic signed [CoordW-1:0] o_a_t;
    logic signed [CoordW-1:0] o_b_s;
    logic signed [CoordW-1:0] o_b_t;
    logic signed [CoordW-1:0] o_c_s;
    logic signed [CoordW-1:0] o_c_t;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CfgIdxW-1:0]       i_cfg_index;
    logic [CoordW-1:0]        i_cfg_data;

    int          mismatch_count;
    int          pending_tris;
    int unsigned quiet_cycles = 0;
    logic        tx_burst;
    logic        rx_burst;

    triangle_primitive_assembler_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_prim_mode (i_prim_mode),
        .i_vert_x    (i_vert_x),
        .i_vert_y    (i_vert_y),
        .i_pen_x     (i_pen_x),
        .i_pen_y     (i_pen_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_a_x       (o_a_x),
        .o_a_y       (o_a_y),
        .o_b_x       (o_b_x),
        .o_b_y       (o_b_y),
        .o_c_x       (o_c_x),
        .o_c_y       (o_c_y),
        .o_a_s       (o_a_s),
        .o_a_t       (o_a_t),
        .o_b_s       (o_b_s),
        .o_b_t       (o_b_t),
        .o_c_s       (o_c_s),
        .o_c_t       (o_c_t),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tpa_triangle_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_func       (i_func),
        .i_prim_mode  (i_prim_mode),
        .i_vert_x     (i_vert_x),
        .i_vert_y     (i_vert_y),
        .i_pen_x      (i_pen_x),
        .i_pen_y      (i_pen_y),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_a_x        (o_a_x),
        .i_a_y        (o_a_y),
        .i_b_x        (o_b_x),
        .i_b_y        (o_b_y),
        .i_c_x        (o_c_x),
        .i_c_y        (o_c_y),
        .i_a_s        (o_a_s),
        .i_a_t        (o_a_t),
        .i_b_s        (o_b_s),
        .i_b_t        (o_b_t),
        .i_c_s        (o_c_s),
        .i_c_t        (o_c_t),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_tris)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Mostly small coordinates so that texture values stay meaningful,
    // with the extremes and full-range values mixed in.
    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return S24_MAX;
            1: return S24_MIN;
            2, 3: return CoordW'($urandom);
            default: return CoordW'($urandom_range(0, 8191)) - CoordW'(4096);
        endcase
    endfunction

    // Called and left at a falling edge.
    task automatic send_item(
        input logic [1:0]               func,
        input logic [1:0]               mode,
        input logic signed [CoordW-1:0] vx,
        input logic signed [CoordW-1:0] vy,
        input logic signed [CoordW-1:0] px,
        input logic signed [CoordW-1:0] py
    );
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func <= func;
        i_prim_mode <= mode;
        i_vert_x <= vx;
        i_vert_y <= vy;
        i_pen_x <= px;
        i_pen_y <= py;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_vertex();
        send_item(FUNC_VERTEX, 2'($urandom), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord());
    endtask

    task automatic send_marker(input logic [1:0] func, input logic [1:0] mode);
        send_item(func, mode, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Leaves the write valid high; the caller lowers it after the last write.
    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Wait until every predicted triangle has come out and the pipeline is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_tris != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    // Mostly well-formed primitives with random content, some stray items.
    task automatic random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned nv;
        int unsigned pick;
        logic [1:0]  mode;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_marker(FUNC_UNUSED, 2'($urandom));
            end else if (pick == 1) begin
                send_marker(FUNC_END, 2'($urandom));
                sent++;
            end else if (pick == 2) begin
                send_vertex();
                sent++;
            end else begin
                mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED
                                                     : 2'($urandom_range(0, 2));
                send_marker(FUNC_BEGIN, mode);
                nv = $urandom_range(1, 12);
                repeat (nv) send_vertex();
                sent += nv + 1;
                if ($urandom_range(0, 3) != 0) begin
                    send_marker(FUNC_END, 2'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(
        input logic              back,
        input logic              tex,
        input logic [CoordW-1:0] inv,
        input int unsigned       n_items,
        input logic              tx_fast,
        input logic              rx_fast
    );
        cfg_write(CFG_BACK_FACE, CoordW'(back));
        cfg_write(CFG_TEX_GEN, CoordW'(tex));
        cfg_write(CFG_INV_HEIGHT, inv);
        i_cfg_valid <= 1'b0;
        tx_burst <= tx_fast;
        rx_burst <= rx_fast;
        random_traffic(n_items / 2);
        drain();
        random_traffic(n_items - n_items / 2);
        drain();
    endtask

    // Result side: random stall before each item, plus a long hold-off now and
    // then so that the block backs up into its input.
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        i_stall = 1'b0;
        taken = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 150 == 40) begin
                gap = LongHold;
            end else if (rx_burst) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 10);
            end
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_VERTEX;
        i_prim_mode = MODE_TRIANGLES;
        i_vert_x = '0;
        i_vert_y = '0;
        i_pen_x = '0;
        i_pen_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BACK_FACE;
        i_cfg_data = '0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Vertices before any begin, with saturating sums in both directions.
        send_item(FUNC_VERTEX, MODE_TRIANGLES, S24_MAX, S24_MAX, S24_MAX, S24_MAX);
        send_item(FUNC_VERTEX, MODE_TRIANGLES, S24_MIN, S24_MIN, S24_MIN, S24_MIN);
        send_item(FUNC_VERTEX, MODE_UNUSED, 24'sd384, -24'sd129, -24'sd1, 24'sd0);
        send_item(FUNC_UNUSED, MODE_STRIP, S24_MAX, S24_MIN, S24_MAX, S24_MIN);
        send_marker(FUNC_BEGIN, MODE_FAN);
        repeat (4) send_vertex();
        // An end in the middle of a fan restarts the fill but keeps the mode.
        send_marker(FUNC_END, MODE_TRIANGLES);
        repeat (3) send_vertex();
        send_marker(FUNC_BEGIN, MODE_STRIP);
        repeat (4) send_vertex();
        send_marker(FUNC_BEGIN, MODE_UNUSED);
        repeat (4) send_vertex();
        send_marker(FUNC_END, MODE_FAN);
        drain();

        // A write to the spare index must leave every register alone.
        cfg_write(CFG_UNUSED, CoordW'($urandom));
        run_phase(1'b1, 1'b1, INV_HEIGHT_RESET, 300, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, CoordW'($urandom), 300, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 24'hFFFFFF, 300, 1'b1, 1'b1);
        run_phase(1'b0, 1'b1, 24'd0, 250, 1'b0, 1'b1);
        // Half scale puts odd positions exactly on a rounding tie.
        run_phase(1'b0, 1'b1, 24'd32768, 300, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, CoordW'($urandom_range(1, 262143)), 300, 1'b0, 1'b0);

        if (mismatch_count == 0 && pending_tris == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
